@@ hw/rtl/ntue_pkg.sv @@
// Neighbor table package: result action codes and the record layouts
// kept in the table memories. No dependencies.
package ntue_pkg;

    // Result action codes
    localparam logic [1:0] ACT_UPDATED  = 2'd0;
    localparam logic [1:0] ACT_INSERTED = 2'd1;
    localparam logic [1:0] ACT_REPLACED = 2'd2;
    localparam logic [1:0] ACT_EXPIRED  = 2'd3;

    localparam int unsigned COUNT_W   = 5;
    localparam logic [4:0]  COUNT_MAX = 5'd31;

    // Fields read during every scan
    typedef struct packed {
        logic [7:0]  node;
        logic [31:0] heard;
    } scan_rec_t;

    // Fields only written, never needed by the scan
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [15:0] sequence_num;
    } body_rec_t;

endpackage

@@ hw/rtl/ntue_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ntue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/neighbour_table_update_expire.sv @@
// Neighbor table top level: item sequencer, valid bits and result register.
// Depends on ntue_pkg and ntue_ram.
//
// Use:
//   Input channel (in_valid/in_ready) carries one item: kind 0 updates a
//   neighbor record, kind 1 frees records older than timeout_limit.
//   Output channel (out_valid/out_ready) returns exactly one result per item.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes timeout_limit; it is
//   always ready and is to be written only while the block is idle.
// Timing:
//   Each item is scanned through the node/heard memory, issuing reads at
//   one entry per cycle; the registered read data of the last entry is then
//   taken in, and the write-back and result load follow, holding while the
//   output register is full.
//   in_ready returns the cycle after the result is loaded, so items are
//   taken one at a time; no new item is taken while one is in progress.
// Reset:
//   All valid bits clear at once, timeout_limit returns to 1000; no memory
//   clearing pass is needed.
// Stall:
//   A result waits in the output register; the next item is still taken and
//   scanned, and its write-back holds until the output register frees up.
module neighbour_table_update_expire #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  node_id,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    input  logic [31:0] vel_z,
    input  logic [15:0] sequence_req,
    input  logic [31:0] time_now,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [3:0]  slot,
    output logic [7:0]  evicted_node,
    output logic [4:0]  expired_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_END = CW'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [31:0] timeout_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    // latched item
    logic                  kind_reg;
    logic [7:0]            node_id_reg;
    logic [31:0]           time_now_reg;
    ntue_pkg::body_rec_t   body_reg;

    // scan pipeline
    logic [CW-1:0] cnt_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          issue;
    logic          last_seen;
    ntue_pkg::scan_rec_t rd_rec;
    logic [31:0]   age;

    // scan findings
    logic          have_match_reg;
    logic [AW-1:0] match_idx_reg;
    logic          have_free_reg;
    logic [AW-1:0] free_idx_reg;
    logic          have_old_reg;
    logic [AW-1:0] old_idx_reg;
    logic [31:0]   old_heard_reg;
    logic [7:0]    old_node_reg;
    logic [4:0]    count_reg;

    // write-back and result
    logic          load;
    logic          wr_en;
    logic [AW-1:0] target;
    logic [1:0]    act_sel;
    ntue_pkg::scan_rec_t wr_rec;

    logic          out_valid_reg;
    logic [1:0]    action_reg;
    logic [3:0]    slot_reg;
    logic [7:0]    evicted_reg;
    logic [4:0]    expired_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign slot          = slot_reg;
    assign evicted_node  = evicted_reg;
    assign expired_count = expired_reg;

    // read issue and end of scan
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < CNT_END);
    assign last_seen = (state_reg == ST_SCAN) && (cnt_reg == CNT_END);
    assign age       = time_now_reg - rd_rec.heard;

    // write-back target selection
    always_comb
    begin
        if (have_match_reg)
        begin
            act_sel = ntue_pkg::ACT_UPDATED;
            target  = match_idx_reg;
        end
        else if (have_free_reg)
        begin
            act_sel = ntue_pkg::ACT_INSERTED;
            target  = free_idx_reg;
        end
        else
        begin
            act_sel = ntue_pkg::ACT_REPLACED;
            target  = old_idx_reg;
        end
    end

    assign load   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign wr_en  = load && !kind_reg;
    assign wr_rec = '{node: node_id_reg, heard: time_now_reg};

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_seen)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= 32'd1000;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;

            if (cfg_valid)
            begin
                timeout_reg <= cfg_data;
            end

            if (in_valid && in_ready)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            // expire clears entries as they stream by
            if (rd_vld_reg && kind_reg && valid_reg[rd_idx_reg] && (age > timeout_reg))
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[target] <= 1'b1;
            end

            // output register
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item latch, scan findings and result payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg <= cnt_reg[AW-1:0];
        end

        if (in_valid && in_ready)
        begin
            kind_reg       <= kind;
            node_id_reg    <= node_id;
            time_now_reg   <= time_now;
            body_reg       <= '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                                vel_x: vel_x, vel_y: vel_y, vel_z: vel_z,
                                sequence_num: sequence_req};
            have_match_reg <= 1'b0;
            have_free_reg  <= 1'b0;
            have_old_reg   <= 1'b0;
            count_reg      <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (valid_reg[rd_idx_reg])
            begin
                if (kind_reg)
                begin
                    if ((age > timeout_reg) && (count_reg != ntue_pkg::COUNT_MAX))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                else
                begin
                    // oldest by raw compare, lowest slot wins ties
                    if (!have_old_reg || (rd_rec.heard < old_heard_reg))
                    begin
                        have_old_reg  <= 1'b1;
                        old_idx_reg   <= rd_idx_reg;
                        old_heard_reg <= rd_rec.heard;
                        old_node_reg  <= rd_rec.node;
                    end
                    if (!have_match_reg && (rd_rec.node == node_id_reg))
                    begin
                        have_match_reg <= 1'b1;
                        match_idx_reg  <= rd_idx_reg;
                    end
                end
            end
            else if (!have_free_reg)
            begin
                have_free_reg <= 1'b1;
                free_idx_reg  <= rd_idx_reg;
            end
        end

        if (load)
        begin
            if (kind_reg)
            begin
                action_reg  <= ntue_pkg::ACT_EXPIRED;
                slot_reg    <= '0;
                evicted_reg <= '0;
                expired_reg <= count_reg;
            end
            else
            begin
                action_reg  <= act_sel;
                slot_reg    <= 4'(target);
                evicted_reg <= (act_sel == ntue_pkg::ACT_REPLACED) ? old_node_reg : 8'd0;
                expired_reg <= '0;
            end
        end
    end

    // node id and last-heard time, scanned every item
    ntue_ram #(
        .WIDTH ($bits(ntue_pkg::scan_rec_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_scan_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (target),
        .wr_data (wr_rec),
        .rd_en   (issue),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_rec)
    );

    // position, velocity and sequence number
    ntue_ram #(
        .WIDTH ($bits(ntue_pkg::body_rec_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_body_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (target),
        .wr_data (body_reg),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

endmodule

@@ test/neighbour_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the neighbor table: keeps its own copy of the table and
// timeout, predicts one result per item transfer and compares every result.
// Depends on ntue_pkg.
module neighbour_result_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  node_id,
    input  logic [31:0] time_now,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  slot,
    input  logic [7:0]  evicted_node,
    input  logic [4:0]  expired_count,
    output int unsigned results_waiting,
    output int unsigned mismatch_count
);

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] slot;
        logic [7:0] evicted_node;
        logic [4:0] expired_count;
    } table_result_t;

    // Only node id and last-heard time steer the results; the record body is
    // never read back, so it is not mirrored here.
    logic                slot_used [TABLE_DEPTH];
    ntue_pkg::scan_rec_t slot_rec  [TABLE_DEPTH];
    logic [31:0]         expire_limit;
    table_result_t       pending_results[$];
    int unsigned         fail_tally = 0;
    int unsigned         waiting_tally = 0;

    assign results_waiting = waiting_tally;
    assign mismatch_count  = fail_tally;

    task automatic report_mismatch(input string msg);
        fail_tally++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Applies one item to the mirrored table and returns its result
    function automatic table_result_t predict_table_result(input logic is_expire,
                                                           input logic [7:0] id,
                                                           input logic [31:0] now);
        table_result_t res;
        int unsigned   freed;
        int            oldest;
        int            free_idx;
        int            match_idx;
        int            target;
        res       = '0;
        freed     = 0;
        oldest    = -1;
        free_idx  = -1;
        match_idx = -1;
        if (is_expire)
        begin
            // wrapping age, strictly above the limit
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_used[i] && (now - slot_rec[i].heard) > expire_limit)
                begin
                    slot_used[i] = 1'b0;
                    freed++;
                end
            end
            res.action        = ntue_pkg::ACT_EXPIRED;
            res.expired_count = (freed > ntue_pkg::COUNT_MAX) ? ntue_pkg::COUNT_MAX
                                                              : freed[4:0];
        end
        else
        begin
            // first match, first free slot, oldest raw time with lowest slot on ties
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    if (oldest < 0 || slot_rec[i].heard < slot_rec[oldest].heard)
                        oldest = i;
                    if (match_idx < 0 && slot_rec[i].node == id)
                        match_idx = i;
                end
                else if (free_idx < 0)
                    free_idx = i;
            end
            if (match_idx >= 0)
            begin
                res.action = ntue_pkg::ACT_UPDATED;
                target     = match_idx;
            end
            else if (free_idx >= 0)
            begin
                res.action = ntue_pkg::ACT_INSERTED;
                target     = free_idx;
            end
            else
            begin
                res.action       = ntue_pkg::ACT_REPLACED;
                target           = oldest;
                res.evicted_node = slot_rec[oldest].node;
            end
            slot_rec[target].node  = id;
            slot_rec[target].heard = now;
            slot_used[target]      = 1'b1;
            res.slot               = target[3:0];
        end
        return res;
    endfunction

    // Watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        table_result_t want;
        if (!rst_n)
        begin
            pending_results.delete();
            expire_limit = 32'd1000;
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_used[i] = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                expire_limit = cfg_data;
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result transfer with none expected, action %0d",
                                              action));
                else
                begin
                    want = pending_results.pop_front();
                    if (action !== want.action)
                        report_mismatch($sformatf("action %0d, expected %0d",
                                                  action, want.action));
                    if (slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  slot, want.slot));
                    if (evicted_node !== want.evicted_node)
                        report_mismatch($sformatf("evicted_node %0d, expected %0d",
                                                  evicted_node, want.evicted_node));
                    if (expired_count !== want.expired_count)
                        report_mismatch($sformatf("expired_count %0d, expected %0d",
                                                  expired_count, want.expired_count));
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(predict_table_result(kind, node_id, time_now));
        end
        waiting_tally = pending_results.size();
    end

endmodule

@@ test/tb_neighbour_table_update_expire.sv @@
`timescale 1ns / 100ps
// Testbench top for the neighbor table: clock, reset, directed and random
// item streams, timeout writes and the verdict.
// Depends on neighbour_table_update_expire and neighbour_result_checker.
module tb_neighbour_table_update_expire;

    localparam logic        KIND_UPDATE   = 1'b0;
    localparam logic        KIND_EXPIRE   = 1'b1;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned PHASE_ITEMS   = 180;
    localparam int unsigned PHASE_COUNT   = 8;

    typedef struct packed {
        logic        kind;
        logic [7:0]  node_id;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [15:0] sequence_req;
        logic [31:0] time_now;
    } nbr_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [7:0]  node_id;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [15:0] sequence_req;
    logic [31:0] time_now;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [7:0]  evicted_node;
    logic [4:0]  expired_count;

    int unsigned results_waiting;
    int unsigned mismatch_count;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    neighbour_table_update_expire i_dut (.*);

    neighbour_result_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_neighbour_table_update_expire NOT OK");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic nbr_item_t update_item(input logic [7:0] id, input logic [31:0] now);
        nbr_item_t it;
        it.kind         = KIND_UPDATE;
        it.node_id      = id;
        it.pos_x        = $urandom;
        it.pos_y        = $urandom;
        it.pos_z        = $urandom;
        it.vel_x        = $urandom;
        it.vel_y        = $urandom;
        it.vel_z        = $urandom;
        it.sequence_req = 16'($urandom_range(0, 65535));
        it.time_now     = now;
        return it;
    endfunction

    function automatic nbr_item_t expire_item(input logic [31:0] now);
        nbr_item_t it;
        it      = update_item(8'($urandom_range(0, 255)), now);
        it.kind = KIND_EXPIRE;
        return it;
    endfunction

    // All tasks below start and end right after a falling edge
    task automatic idle_input();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_item(input nbr_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
            idle_input();
        in_valid     <= 1'b1;
        kind         <= it.kind;
        node_id      <= it.node_id;
        pos_x        <= it.pos_x;
        pos_y        <= it.pos_y;
        pos_z        <= it.pos_z;
        vel_x        <= it.vel_x;
        vel_y        <= it.vel_y;
        vel_z        <= it.vel_z;
        sequence_req <= it.sequence_req;
        time_now     <= it.time_now;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_results();
        idle_input();
        while (results_waiting != 0)
            @(negedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] limit_ms);
        cfg_valid <= 1'b1;
        cfg_data  <= limit_ms;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: a running clock, ids mostly from a pool a bit larger
    // than the table so matches, inserts and replacements all occur
    task automatic run_phase(input int unsigned n_items, input logic [31:0] limit_ms,
                             input logic [31:0] start_ms);
        logic [31:0] clock_ms;
        logic [31:0] step_max;
        logic [31:0] stamp;
        logic [7:0]  id_base;
        logic [7:0]  id;
        clock_ms = start_ms;
        step_max = (limit_ms < 32'd20000) ? limit_ms / 4 + 1 : 32'd2000;
        id_base  = 8'($urandom_range(0, 234));
        repeat (n_items)
        begin
            if ($urandom_range(0, 49) == 0)
                drain_results();
            clock_ms += $urandom_range(0, step_max);
            if ($urandom_range(0, 99) < 85)
                id = 8'(id_base + $urandom_range(0, 21));
            else
                id = 8'($urandom_range(0, 255));
            // stray timestamps give wrapped ages and out-of-order heard times
            stamp = ($urandom_range(0, 99) < 4) ? $urandom : clock_ms;
            if ($urandom_range(0, 99) < 15)
                push_item(expire_item(stamp));
            else
                push_item(update_item(id, stamp));
        end
    endtask

    function automatic logic [31:0] phase_timeout(input int p);
        case (p)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1000;
            3: return 32'd1;
            4: return $urandom_range(50, 5000);
            5: return $urandom;
            6: return 32'd300;
            default: return 32'hFFFF_FFFE;
        endcase
    endfunction

    initial
    begin : stimulus
        nbr_item_t   it;
        logic [31:0] limit_ms;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        kind         = KIND_UPDATE;
        node_id      = '0;
        pos_x        = '0;
        pos_y        = '0;
        pos_z        = '0;
        vel_x        = '0;
        vel_y        = '0;
        vel_z        = '0;
        sequence_req = '0;
        time_now     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset timeout of 1000 ms
        push_item(expire_item(32'd0));                  // expire on an empty table
        it              = update_item(8'd0, 32'hFFFF_FFFF);
        it.pos_x        = '1;
        it.pos_y        = '1;
        it.pos_z        = '1;
        it.vel_x        = 32'h7FFF_FFFF;
        it.vel_y        = 32'hFFFF_FFFF;
        it.vel_z        = 32'h8000_0000;
        it.sequence_req = '1;
        push_item(it);
        it              = update_item(8'd255, 32'd0);
        it.pos_x        = '0;
        it.pos_y        = '0;
        it.pos_z        = '0;
        it.vel_x        = 32'h8000_0000;
        it.vel_y        = '0;
        it.vel_z        = 32'h7FFF_FFFF;
        it.sequence_req = '0;
        push_item(it);
        push_item(update_item(8'd0, 32'd5));            // same id rewrites its record
        for (int n = 1; n <= 14; n++)                   // fill the table, equal times
            push_item(update_item(n[7:0], 32'd100));
        push_item(update_item(8'd200, 32'd200));        // full: replace smallest time
        push_item(update_item(8'd201, 32'd300));
        push_item(update_item(8'd202, 32'd300));        // tie: lowest slot wins
        push_item(expire_item(32'd1100));               // age equal to the limit stays
        push_item(expire_item(32'd1101));               // one past the limit goes
        push_item(expire_item(32'd5));                  // wrapped ages

        // Random phases, each after a quiet table and a new timeout
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(negedge clk);
            limit_ms = phase_timeout(p);
            write_timeout(limit_ms);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            run_phase(PHASE_ITEMS, limit_ms, (p == 2) ? 32'hFFFF_F000 : $urandom);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb_neighbour_table_update_expire OK");
        else
            $display("tb_neighbour_table_update_expire NOT OK");
        $finish;
    end

endmodule
